/* rtl/core/kls_pkg.sv */
// ----------------------------------------------------------------------------
// kls_pkg
// Shared types, widths and helpers for the streaming kth-largest selector.
// ----------------------------------------------------------------------------
package kls_pkg;

  // Heap depth: largest rank that can be served
  localparam int KMax   = 64;
  localparam int AddrW  = (KMax > 1) ? $clog2(KMax) : 1;
  localparam int CntW   = $clog2(KMax + 1);
  localparam int ChildW = AddrW + 2;
  localparam int DataW  = 32;
  localparam int RankW  = 7;

  // Flipping the sign bit turns a signed value into an order-preserving key
  localparam logic [DataW-1:0] SignFlip = {1'b1, {(DataW-1){1'b0}}};

  typedef enum logic [2:0] {
    StIdle,
    StUp,
    StUpEnd,
    StRoot,
    StDown,
    StFinRd,
    StFin
  } state_e;

  // Request to the heap memory: one write port, two read ports
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re_a;
    logic [AddrW-1:0] raddr_a;
    logic             re_b;
    logic [AddrW-1:0] raddr_b;
  } ram_req_t;

  // Effective rank: zero acts as one, anything above the depth is clamped
  function automatic logic [CntW-1:0] eff_k(input logic [RankW-1:0] rank);
    logic [CntW-1:0] k;
    if (rank == '0) begin
      k = CntW'(1);
    end else if (int'(rank) > KMax) begin
      k = CntW'(KMax);
    end else begin
      k = CntW'(rank);
    end
    return k;
  endfunction

endpackage

/* rtl/core/kth_largest_stream_select.sv */
// An insert reads the parent, then climbs one level per step (an empty heap is written
// directly); a root replacement reads the root, then both children, and sinks one
// level per step; a value too small for a full heap only reads the root and compares.
// One read-compare-write per level; an item marked last reads the root for the result.
// One item is in work at a time; a waiting result does not stop new items unless they
// need the output register. Reset empties the heap (count to zero) and sets rank to 1.
// ----------------------------------------------------------------------------
// kth_largest_stream_select
// Min-heap of the k largest values seen; reports the kth largest per set.
// ----------------------------------------------------------------------------
module kth_largest_stream_select (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: rank_k
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [kls_pkg::RankW-1:0]  cfg_data_i,
  // Input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [kls_pkg::DataW-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                       s_axis_tlast,
  // Result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [kls_pkg::DataW-1:0]  m_axis_tdata,   // [31:0] kth_value
  output logic                       m_axis_tuser    // [0] valid_res
);

  localparam int AddrW  = kls_pkg::AddrW;
  localparam int CntW   = kls_pkg::CntW;
  localparam int ChildW = kls_pkg::ChildW;
  localparam int DataW  = kls_pkg::DataW;

  kls_pkg::state_e state_q, state_d;

  logic [kls_pkg::RankW-1:0] rank_q;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           k_q, k_d;
  logic [AddrW-1:0]          pos_q, pos_d;
  logic [DataW-1:0]          key_q, key_d;
  logic                      last_q, last_d;

  logic                      out_valid_q, out_valid_d;
  logic [DataW-1:0]          kth_q, kth_d;
  logic                      vres_q, vres_d;
  logic                      out_load;

  kls_pkg::ram_req_t         ram_req;
  logic [DataW-1:0]          rdata_a, rdata_b;

  logic                      s_accept;
  logic [CntW-1:0]           k_in;
  logic [AddrW-1:0]          parent;
  logic [ChildW-1:0]         child_l, child_r, child_sel, next_l, next_r;
  logic [DataW-1:0]          min_val;
  logic                      take_child;

  // Heap storage
  kls_heap_ram u_heap_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= kls_pkg::RankW'(1);
    end else if (cfg_valid_i) begin
      rank_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == kls_pkg::StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign k_in          = kls_pkg::eff_k(rank_q);

  // Heap index arithmetic
  assign parent   = AddrW'((pos_q - AddrW'(1)) >> 1);
  assign child_l  = {1'b0, pos_q, 1'b1};
  assign child_r  = child_l + ChildW'(1);

  // Smallest of key, left and right child (earlier wins a tie)
  always_comb begin
    min_val    = key_q;
    child_sel  = child_l;
    take_child = 1'b0;
    if (child_l < ChildW'(count_q) && rdata_a < min_val) begin
      min_val    = rdata_a;
      child_sel  = child_l;
      take_child = 1'b1;
    end
    if (child_r < ChildW'(count_q) && rdata_b < min_val) begin
      min_val    = rdata_b;
      child_sel  = child_r;
      take_child = 1'b1;
    end
  end

  assign next_l = {child_sel[ChildW-2:0], 1'b1};
  assign next_r = next_l + ChildW'(1);

  // Next state, heap updates and memory requests
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    k_d      = k_q;
    pos_d    = pos_q;
    key_d    = key_q;
    last_d   = last_q;
    out_load = 1'b0;
    ram_req  = '0;

    case (state_q)
      kls_pkg::StIdle: begin
        if (s_accept) begin
          key_d  = s_axis_tdata ^ kls_pkg::SignFlip;
          last_d = s_axis_tlast;
          k_d    = k_in;
          if (count_q < k_in) begin
            // Insert: open a hole at the end and move it up
            count_d = count_q + CntW'(1);
            if (count_q == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = s_axis_tdata ^ kls_pkg::SignFlip;
              state_d       = s_axis_tlast ? kls_pkg::StFinRd : kls_pkg::StIdle;
            end else begin
              pos_d           = AddrW'(count_q);
              ram_req.re_a    = 1'b1;
              ram_req.raddr_a = AddrW'((count_q - CntW'(1)) >> 1);
              state_d         = kls_pkg::StUp;
            end
          end else begin
            // Full: fetch the root to compare against
            ram_req.re_a    = 1'b1;
            ram_req.raddr_a = '0;
            state_d         = kls_pkg::StRoot;
          end
        end
      end

      kls_pkg::StUp: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_q;
        if (rdata_a > key_q) begin
          // Pull the parent down into the hole
          ram_req.wdata = rdata_a;
          pos_d         = parent;
          if (parent == '0) begin
            state_d = kls_pkg::StUpEnd;
          end else begin
            ram_req.re_a    = 1'b1;
            ram_req.raddr_a = AddrW'((parent - AddrW'(1)) >> 1);
          end
        end else begin
          ram_req.wdata = key_q;
          state_d       = last_q ? kls_pkg::StFinRd : kls_pkg::StIdle;
        end
      end

      kls_pkg::StUpEnd: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = key_q;
        state_d       = last_q ? kls_pkg::StFinRd : kls_pkg::StIdle;
      end

      kls_pkg::StRoot: begin
        if (key_q > rdata_a) begin
          // Replace the root: fetch both children
          pos_d           = '0;
          ram_req.re_a    = 1'b1;
          ram_req.raddr_a = AddrW'(1);
          ram_req.re_b    = 1'b1;
          ram_req.raddr_b = AddrW'(2);
          state_d         = kls_pkg::StDown;
        end else begin
          state_d = last_q ? kls_pkg::StFinRd : kls_pkg::StIdle;
        end
      end

      kls_pkg::StDown: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_q;
        ram_req.wdata = min_val;
        if (take_child) begin
          // Lift the smaller child and follow the hole down
          pos_d           = child_sel[AddrW-1:0];
          ram_req.re_a    = 1'b1;
          ram_req.raddr_a = next_l[AddrW-1:0];
          ram_req.re_b    = 1'b1;
          ram_req.raddr_b = next_r[AddrW-1:0];
        end else begin
          state_d = last_q ? kls_pkg::StFinRd : kls_pkg::StIdle;
        end
      end

      kls_pkg::StFinRd: begin
        ram_req.re_a    = 1'b1;
        ram_req.raddr_a = '0;
        state_d         = kls_pkg::StFin;
      end

      kls_pkg::StFin: begin
        // Hold until the output register is free, then empty the heap
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          count_d  = '0;
          state_d  = kls_pkg::StIdle;
        end
      end

      default: begin
        state_d = kls_pkg::StIdle;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    kth_d       = kth_q;
    vres_d      = vres_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      vres_d      = (count_q >= k_q);
      kth_d       = (count_q >= k_q) ? (rdata_a ^ kls_pkg::SignFlip) : '0;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kls_pkg::StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    last_q <= last_d;
    kth_q  <= kth_d;
    vres_q <= vres_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = kth_q;
  assign m_axis_tuser  = vres_q;

  // Heap never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= kls_pkg::KMax)
    else $error("heap count above depth");

  // The hole moving up never sits at the root
  a_up_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kls_pkg::StUp |-> pos_q != '0)
    else $error("sift-up hole at root");

  // Loading a result empties the heap
  a_fin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> count_q == '0 && out_valid_q)
    else $error("heap not emptied after result");

  // No memory write while idle without a new item
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kls_pkg::StIdle && !s_accept |-> !ram_req.we)
    else $error("stray heap write");

  // A result flagged short carries zero
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !vres_q |-> kth_q == '0)
    else $error("short result not zero");

endmodule

/* rtl/core/kls_heap_ram.sv */
// ----------------------------------------------------------------------------
// kls_heap_ram
// Heap storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module kls_heap_ram (
  input  logic                      clk_i,
  input  kls_pkg::ram_req_t         req_i,
  output logic [kls_pkg::DataW-1:0] rdata_a_o,
  output logic [kls_pkg::DataW-1:0] rdata_b_o
);

  logic [kls_pkg::DataW-1:0] mem_q [kls_pkg::KMax];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re_a) begin
      rdata_a_o <= mem_q[req_i.raddr_a];
    end
    if (req_i.re_b) begin
      rdata_b_o <= mem_q[req_i.raddr_b];
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed sets into the kth-largest selector under random rank
// settings, tracks the k largest values of each set in a software multiset
// and compares every reported kth value and validity flag as it leaves.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RandomItems  = 1150;
  localparam int unsigned SettleCycles = 16;

  localparam logic [kls_pkg::DataW-1:0] ValMax  = 32'h7fff_ffff;
  localparam logic [kls_pkg::DataW-1:0] ValMin  = 32'h8000_0000;
  localparam logic [kls_pkg::DataW-1:0] ValOnes = 32'hffff_ffff;

  typedef struct packed {
    logic [kls_pkg::DataW-1:0] kth_value;
    logic                      valid_res;
  } kth_result_t;

  // Tracks the values held for the open set and the results still owed
  class kth_scoreboard;
    logic [kls_pkg::DataW-1:0] held_keys[$];
    logic [kls_pkg::RankW-1:0] rank;
    kth_result_t               awaited[$];
    int unsigned               errors;
    int unsigned               full_sets;
    int unsigned               short_sets;

    function new();
      rank       = kls_pkg::RankW'(1);
      errors     = 0;
      full_sets  = 0;
      short_sets = 0;
    endfunction

    // Zero counts as one, anything past the heap depth is held at the depth
    function int unsigned active_depth();
      if (rank == '0) return 1;
      if (int'(rank) > kls_pkg::KMax) return kls_pkg::KMax;
      return int'(rank);
    endfunction

    function int unsigned lowest_slot();
      int unsigned slot;
      slot = 0;
      foreach (held_keys[i]) begin
        if (held_keys[i] < held_keys[slot]) slot = i;
      end
      return slot;
    endfunction

    function void note_rank(input logic [kls_pkg::RankW-1:0] new_rank);
      rank = new_rank;
    endfunction

    function void note_value(input logic [kls_pkg::DataW-1:0] value, input logic last_flag);
      logic [kls_pkg::DataW-1:0] key;
      int unsigned               depth;
      int unsigned               slot;
      kth_result_t               res;
      key   = value ^ kls_pkg::SignFlip;
      depth = active_depth();
      // Fill up to k, then displace the smallest only by a strictly larger key
      if (held_keys.size() < depth) begin
        held_keys.push_back(key);
      end else begin
        slot = lowest_slot();
        if (key > held_keys[slot]) held_keys[slot] = key;
      end
      if (last_flag) begin
        if (held_keys.size() >= depth) begin
          res.kth_value = held_keys[lowest_slot()] ^ kls_pkg::SignFlip;
          res.valid_res = 1'b1;
          full_sets++;
        end else begin
          res.kth_value = '0;
          res.valid_res = 1'b0;
          short_sets++;
        end
        awaited.push_back(res);
        held_keys.delete();
      end
    endfunction

    function void check_result(input logic [kls_pkg::DataW-1:0] kth_value,
                               input logic valid_res);
      kth_result_t want;
      if (awaited.size() == 0) begin
        $error("result with none awaited: kth_value %h valid_res %b", kth_value, valid_res);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (kth_value !== want.kth_value) begin
        $error("kth_value: expected %h, actual %h", want.kth_value, kth_value);
        errors++;
      end
      if (valid_res !== want.valid_res) begin
        $error("valid_res: expected %b, actual %b", want.valid_res, valid_res);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [kls_pkg::RankW-1:0] cfg_data_i;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [kls_pkg::DataW-1:0] s_axis_tdata;   // [31:0] value
  logic                      s_axis_tlast;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [kls_pkg::DataW-1:0] m_axis_tdata;   // [31:0] kth_value
  logic                      m_axis_tuser;   // [0] valid_res

  kth_scoreboard sb;
  bit            quiet_mode;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  int unsigned   items_sent;
  int unsigned   ranks_written;

  kth_largest_stream_select dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none at all in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Full-range values, a narrow band that forces ties, and the extremes
  function automatic logic [kls_pkg::DataW-1:0] random_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom;
    if (roll < 85) return kls_pkg::DataW'($urandom_range(0, 15)) - kls_pkg::DataW'(8);
    case ($urandom_range(0, 3))
      0:       return ValMin;
      1:       return ValMax;
      2:       return ValOnes;
      default: return '0;
    endcase
  endfunction

  // Accept results, check them and stall the result side at random
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("kth_largest_stream_select verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet_mode && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  // Offer one request; valid stays high when the next follows without a gap
  task automatic send_item(input logic [kls_pkg::DataW-1:0] value, input logic last_flag);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last_flag;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_value(value, last_flag);
    items_sent++;
  endtask

  // Hold the sender until every owed result is out, then let the heap settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_rank(input logic [kls_pkg::RankW-1:0] new_rank);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= new_rank;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.note_rank(new_rank);
    ranks_written++;
  endtask

  initial begin
    int unsigned               random_items;
    int unsigned               pick;
    int unsigned               depth;
    int unsigned               n_sets;
    int unsigned               set_len;
    logic [kls_pkg::RankW-1:0] new_rank;

    sb            = new();
    quiet_mode    = 1'b0;
    items_sent    = 0;
    ranks_written = 0;
    random_items  = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset rank picks the maximum: single-value sets at both extremes
    send_item(ValMax, 1'b1);
    send_item(ValMin, 1'b1);
    send_item(ValOnes, 1'b0);
    send_item('0, 1'b0);
    send_item(32'd1, 1'b1);

    // Ties at a full heap, then a set too short for the rank
    wait_drained();
    write_rank(kls_pkg::RankW'(3));
    repeat (3) send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b1);
    send_item(32'd7, 1'b0);
    send_item(32'd2, 1'b1);

    // Rank zero behaves as rank one
    wait_drained();
    write_rank('0);
    send_item(-32'sd5, 1'b0);
    send_item(32'd9, 1'b0);
    send_item(-32'sd2, 1'b1);

    // Every rank bit set: clamps to the full depth, one value is too few
    wait_drained();
    write_rank('1);
    send_item(32'd1, 1'b1);

    // Shrink and grow the rank while a set is still open
    wait_drained();
    write_rank(kls_pkg::RankW'(2));
    send_item(32'd10, 1'b0);
    send_item(32'd20, 1'b0);
    send_item(32'd30, 1'b0);
    wait_drained();
    write_rank(kls_pkg::RankW'(1));
    send_item(32'd25, 1'b0);
    send_item(32'd15, 1'b0);
    wait_drained();
    write_rank(kls_pkg::RankW'(3));
    send_item(ValMin, 1'b1);

    // Random phases: a fresh rank each time, sets around the rank in length
    while (random_items < RandomItems) begin
      wait_drained();
      quiet_mode = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      case (pick)
        0:          new_rank = '0;
        1:          new_rank = kls_pkg::RankW'(1);
        2:          new_rank = kls_pkg::RankW'(kls_pkg::KMax);
        3:          new_rank = kls_pkg::RankW'($urandom_range(kls_pkg::KMax + 1, 127));
        4, 5, 6:    new_rank = kls_pkg::RankW'($urandom_range(2, 8));
        default:    new_rank = kls_pkg::RankW'($urandom_range(1, kls_pkg::KMax));
      endcase
      write_rank(new_rank);
      depth  = sb.active_depth();
      n_sets = (depth > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      repeat (n_sets) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          set_len = (depth > 1) ? $urandom_range(1, depth - 1) : 1;
        end else if (pick < 8) begin
          set_len = depth + $urandom_range(0, 8);
        end else begin
          set_len = depth + $urandom_range(9, depth + 10);
        end
        for (int i = 1; i <= set_len; i++) send_item(random_value(), i == set_len);
        random_items += set_len;
      end
      // Now and then leave a set open so the next rank lands mid-set
      if ($urandom_range(0, 7) == 0) begin
        set_len = $urandom_range(1, 10);
        repeat (set_len) send_item(random_value(), 1'b0);
        random_items += set_len;
      end
    end

    // Close any open set, then drain
    send_item(random_value(), 1'b1);
    quiet_mode = 1'b0;
    wait_drained();

    $display("Ran %0d values through %0d rank settings, zero and clamped ranks included.",
             items_sent, ranks_written);
    $display("Sets closed: %0d with enough values, %0d short of the rank.",
             sb.full_sets, sb.short_sets);
    if (sb.errors == 0) begin
      $display("kth_largest_stream_select verification clean");
    end else begin
      $display("kth_largest_stream_select verification failed");
    end
    $finish;
  end

endmodule
